### rtl/spring_damper_link_2d_top_defines.svh
// assertion macros for the spring damper link top level
// used by spring_damper_link_2d_top only
`ifndef SPRING_DAMPER_LINK_2D_TOP_DEFINES_SVH
`define SPRING_DAMPER_LINK_2D_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SDL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SDL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sdl_pkg.sv
// shared types, codes and helpers for the spring damper link
// no dependencies
package sdl_pkg;

    localparam int SQRT_STEPS = 33;
    localparam int DIV_STEPS  = 32;
    localparam int CNT_W      = 6;

    localparam logic [30:0] LEN_MAX_RST = 31'd655360000;
    localparam logic [31:0] MUSCLE_RST  = 32'd65536;

    typedef enum logic [1:0] {
        REQ_COMPUTE = 2'd0,
        REQ_CLEAR   = 2'd1,
        REQ_LOAD    = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        CFG_STIFFNESS = 3'd0,
        CFG_LINK_DAMP = 3'd1,
        CFG_REST_LEN  = 3'd2,
        CFG_MASS_DAMP = 3'd3,
        CFG_LEN_MIN   = 3'd4,
        CFG_LEN_MAX   = 3'd5,
        CFG_MUSCLE    = 3'd6,
        CFG_UNUSED    = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        MUL_DXDX = 4'd0,
        MUL_DYDY = 4'd1,
        MUL_RM   = 4'd2,
        MUL_D1X  = 4'd3,
        MUL_D1Y  = 4'd4,
        MUL_D2X  = 4'd5,
        MUL_D2Y  = 4'd6,
        MUL_SE   = 4'd7,
        MUL_DC   = 4'd8,
        MUL_AX   = 4'd9,
        MUL_AY   = 4'd10
    } t_mul_sel;

    typedef enum logic [3:0] {
        CAP_NONE = 4'd0,
        CAP_SQX  = 4'd1,
        CAP_RAD  = 4'd2,
        CAP_TGT  = 4'd3,
        CAP_DM1X = 4'd4,
        CAP_DM1Y = 4'd5,
        CAP_DM2X = 4'd6,
        CAP_DM2Y = 4'd7,
        CAP_SF   = 4'd8,
        CAP_F    = 4'd9,
        CAP_NUMX = 4'd10,
        CAP_NUMY = 4'd11
    } t_cap;

    typedef struct packed {
        logic     load;
        logic     hist_clear;
        logic     hist_load;
        logic     diff;
        logic     sqrt_init;
        logic     sqrt_step;
        logic     chk;
        logic     div_init_x;
        logic     div_init_y;
        logic     div_step;
        logic     div_cap_x;
        logic     div_cap_y;
        logic     fin;
        t_mul_sel mul_sel;
        t_cap     cap;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic in_range;
        logic out_full;
    } t_stat;

    function automatic logic f_ovf(input logic signed [51:0] v);
        f_ovf = !((&v[51:31]) || !(|v[51:31]));
    endfunction

    function automatic logic [31:0] f_clip(input logic signed [51:0] v);
        if (f_ovf(v)) begin
            f_clip = v[51] ? 32'h8000_0000 : 32'h7fff_ffff;
        end else begin
            f_clip = v[31:0];
        end
    endfunction

endpackage

### rtl/spring_damper_link_2d_top.sv
// 2D spring damper link between two point masses, Q16.16 fixed point.
// A reset or load beat goes from decode back to idle. A compute beat
// runs, when the length lies inside the limits, a 33 step square root
// and two 32 step divides, plus 11 products through the one shared 33x33
// multiplier and the steps around them; outside the limits it goes from
// the range check to the last step. One beat is in work at a time; a
// finished result waits in the output register while the next beat is
// taken, and the next result holds in its last step until that register
// is free. Depends on sdl_pkg, sdl_ctrl, sdl_datapath and the defines header.
`include "spring_damper_link_2d_top_defines.svh"

module spring_damper_link_2d_top import sdl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_mass1_x,
    input  logic [31:0] i_mass1_y,
    input  logic [31:0] i_mass2_x,
    input  logic [31:0] i_mass2_y,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_force1_x,
    output logic [31:0] o_force1_y,
    output logic [31:0] o_force2_x,
    output logic [31:0] o_force2_y,
    output logic        o_saturated
);

    t_cmd  w_cmd;
    t_stat w_stat;

    sdl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    sdl_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req_type  (i_req_type),
        .i_mass1_x   (i_mass1_x),
        .i_mass1_y   (i_mass1_y),
        .i_mass2_x   (i_mass2_x),
        .i_mass2_y   (i_mass2_y),
        .i_out_ready (i_ready),
        .o_out_valid (o_valid),
        .o_force1_x  (o_force1_x),
        .o_force1_y  (o_force1_y),
        .o_force2_x  (o_force2_x),
        .o_force2_y  (o_force2_y),
        .o_saturated (o_saturated),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

    `SDL_ASSERT_NEXT(a_busy_after_accept, i_valid && o_ready, !o_ready, "ready after accept")
    `SDL_ASSERT_NOW(a_no_overwrite, w_cmd.fin, !o_valid || i_ready, "result overwritten")
    `SDL_ASSERT_NOW(a_one_unit, 1'b1, $onehot0({w_cmd.sqrt_step, w_cmd.div_step, w_cmd.load, w_cmd.fin}), "units overlap")

endmodule

### rtl/sdl_ctrl.sv
// sequencer for the spring damper link: steps the shared multiplier,
// square root and divider; depends on sdl_pkg
module sdl_ctrl import sdl_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [23:0] {
        S_IDLE    = 24'h000001,
        S_DEC     = 24'h000002,
        S_DIFF    = 24'h000004,
        S_M_SQX   = 24'h000008,
        S_M_SQY   = 24'h000010,
        S_M_TGT   = 24'h000020,
        S_M_D1X   = 24'h000040,
        S_M_D1Y   = 24'h000080,
        S_M_D2X   = 24'h000100,
        S_M_D2Y   = 24'h000200,
        S_SQ_INIT = 24'h000400,
        S_SQRT    = 24'h000800,
        S_CHK     = 24'h001000,
        S_M_SE    = 24'h002000,
        S_M_DC    = 24'h004000,
        S_F_SUM   = 24'h008000,
        S_M_AX    = 24'h010000,
        S_M_AY    = 24'h020000,
        S_DX_INIT = 24'h040000,
        S_DIVX    = 24'h080000,
        S_DY_INIT = 24'h100000,
        S_DIVY    = 24'h200000,
        S_DY_END  = 24'h400000,
        S_FIN     = 24'h800000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_cmd             w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        w_cmd   = '0;
        w_cmd.mul_sel = MUL_DXDX;
        w_cmd.cap     = CAP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                unique case (i_stat.req)
                    REQ_COMPUTE: n_state = S_DIFF;
                    REQ_CLEAR: begin
                        w_cmd.hist_clear = 1'b1;
                        n_state          = S_IDLE;
                    end
                    REQ_LOAD: begin
                        w_cmd.hist_load = 1'b1;
                        n_state         = S_IDLE;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_DIFF: begin
                w_cmd.diff = 1'b1;
                n_state    = S_M_SQX;
            end
            S_M_SQX: begin
                w_cmd.mul_sel = MUL_DXDX;
                n_state       = S_M_SQY;
            end
            S_M_SQY: begin
                w_cmd.mul_sel = MUL_DYDY;
                w_cmd.cap     = CAP_SQX;
                n_state       = S_M_TGT;
            end
            S_M_TGT: begin
                w_cmd.mul_sel = MUL_RM;
                w_cmd.cap     = CAP_RAD;
                n_state       = S_M_D1X;
            end
            S_M_D1X: begin
                w_cmd.mul_sel = MUL_D1X;
                w_cmd.cap     = CAP_TGT;
                n_state       = S_M_D1Y;
            end
            S_M_D1Y: begin
                w_cmd.mul_sel = MUL_D1Y;
                w_cmd.cap     = CAP_DM1X;
                n_state       = S_M_D2X;
            end
            S_M_D2X: begin
                w_cmd.mul_sel = MUL_D2X;
                w_cmd.cap     = CAP_DM1Y;
                n_state       = S_M_D2Y;
            end
            S_M_D2Y: begin
                w_cmd.mul_sel = MUL_D2Y;
                w_cmd.cap     = CAP_DM2X;
                n_state       = S_SQ_INIT;
            end
            S_SQ_INIT: begin
                w_cmd.cap       = CAP_DM2Y;
                w_cmd.sqrt_init = 1'b1;
                n_cnt           = CNT_W'(SQRT_STEPS - 1);
                n_state         = S_SQRT;
            end
            S_SQRT: begin
                w_cmd.sqrt_step = 1'b1;
                n_cnt           = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                w_cmd.chk = 1'b1;
                n_state   = i_stat.in_range ? S_M_SE : S_FIN;
            end
            S_M_SE: begin
                w_cmd.mul_sel = MUL_SE;
                n_state       = S_M_DC;
            end
            S_M_DC: begin
                w_cmd.mul_sel = MUL_DC;
                w_cmd.cap     = CAP_SF;
                n_state       = S_F_SUM;
            end
            S_F_SUM: begin
                w_cmd.cap = CAP_F;
                n_state   = S_M_AX;
            end
            S_M_AX: begin
                w_cmd.mul_sel = MUL_AX;
                n_state       = S_M_AY;
            end
            S_M_AY: begin
                w_cmd.mul_sel = MUL_AY;
                w_cmd.cap     = CAP_NUMX;
                n_state       = S_DX_INIT;
            end
            S_DX_INIT: begin
                w_cmd.cap        = CAP_NUMY;
                w_cmd.div_init_x = 1'b1;
                n_cnt            = CNT_W'(DIV_STEPS - 1);
                n_state          = S_DIVX;
            end
            S_DIVX: begin
                w_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DY_INIT;
                end
            end
            S_DY_INIT: begin
                w_cmd.div_cap_x  = 1'b1;
                w_cmd.div_init_y = 1'b1;
                n_cnt            = CNT_W'(DIV_STEPS - 1);
                n_state          = S_DIVY;
            end
            S_DIVY: begin
                w_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DY_END;
                end
            end
            S_DY_END: begin
                w_cmd.div_cap_y = 1'b1;
                n_state         = S_FIN;
            end
            S_FIN: begin
                if (!i_stat.out_full) begin
                    w_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_cmd   = w_cmd;

endmodule

### rtl/sdl_datapath.sv
// datapath of the spring damper link: config and history registers,
// shared multiplier, square root, divider, output register; uses sdl_pkg
module sdl_datapath import sdl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_mass1_x,
    input  logic [31:0] i_mass1_y,
    input  logic [31:0] i_mass2_x,
    input  logic [31:0] i_mass2_y,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [31:0] o_force1_x,
    output logic [31:0] o_force1_y,
    output logic [31:0] o_force2_x,
    output logic [31:0] o_force2_y,
    output logic        o_saturated,
    input  t_cmd        i_cmd,
    output t_stat       o_stat
);

    // configuration
    logic [31:0] r_stiff, r_ldamp, r_mdamp, r_muscle;
    logic [30:0] r_rest, r_lmin, r_lmax;
    // history
    logic [31:0] r_pm1x, r_pm1y, r_pm2x, r_pm2y, r_pdist;
    // current beat
    t_req        r_req;
    logic [31:0] r_x1, r_y1, r_x2, r_y2;
    logic signed [32:0] r_dx, r_dy;
    // products and intermediates
    logic signed [65:0] r_prod;
    logic [64:0] r_sqx;
    logic [65:0] r_rad;
    logic signed [49:0] r_tgt, r_dm1x, r_dm1y, r_dm2x, r_dm2y, r_sf;
    logic [31:0] r_err, r_chg, r_af;
    logic [64:0] r_numx, r_numy;
    logic        r_negx, r_negy, r_sat, r_fneg;
    // square root and divider
    logic [34:0] r_rem;
    logic [32:0] r_root;
    logic [32:0] r_drem;
    logic [31:0] r_dq;
    logic signed [32:0] r_fx, r_fy;
    // output register
    logic        r_out_valid, r_out_sat;
    logic [31:0] r_f1x, r_f1y, r_f2x, r_f2y;

    logic signed [32:0] w_ma, w_mb, w_dmp;
    logic signed [65:0] w_prod;
    logic [64:0] w_pmag;
    logic [36:0] w_rsh, w_trial, w_rdiff;
    logic [33:0] w_dsh, w_ddiff;
    logic signed [51:0] w_err, w_chg, w_fsum, w_f1x, w_f1y, w_f2x, w_f2y;
    logic [31:0] w_fclip;
    logic        w_in_range;

    assign w_dmp = {r_mdamp[31], r_mdamp};

    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_DXDX: begin w_ma = r_dx; w_mb = r_dx; end
            MUL_DYDY: begin w_ma = r_dy; w_mb = r_dy; end
            MUL_RM:   begin w_ma = {2'b00, r_rest}; w_mb = {r_muscle[31], r_muscle}; end
            MUL_D1X:  begin w_ma = {r_pm1x[31], r_pm1x} - {r_x1[31], r_x1}; w_mb = w_dmp; end
            MUL_D1Y:  begin w_ma = {r_pm1y[31], r_pm1y} - {r_y1[31], r_y1}; w_mb = w_dmp; end
            MUL_D2X:  begin w_ma = {r_pm2x[31], r_pm2x} - {r_x2[31], r_x2}; w_mb = w_dmp; end
            MUL_D2Y:  begin w_ma = {r_pm2y[31], r_pm2y} - {r_y2[31], r_y2}; w_mb = w_dmp; end
            MUL_SE:   begin w_ma = {r_stiff[31], r_stiff}; w_mb = {r_err[31], r_err}; end
            MUL_DC:   begin w_ma = {r_ldamp[31], r_ldamp}; w_mb = {r_chg[31], r_chg}; end
            MUL_AX:   begin w_ma = {1'b0, r_af}; w_mb = r_dx; end
            MUL_AY:   begin w_ma = {1'b0, r_af}; w_mb = r_dy; end
            default:  begin w_ma = '0; w_mb = '0; end
        endcase
    end

    assign w_prod = w_ma * w_mb;
    assign w_pmag = r_prod[65] ? 65'(-r_prod) : r_prod[64:0];

    // one root bit per step of the square root
    assign w_rsh   = {r_rem, r_rad[65:64]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_rdiff = w_rsh - w_trial;

    // restoring divide by the root
    assign w_dsh  = {r_drem, r_dq[31]};
    assign w_ddiff = w_dsh - {1'b0, r_root};

    assign w_err = $signed({19'd0, r_root}) - {{2{r_tgt[49]}}, r_tgt};
    assign w_chg = $signed({19'd0, r_root}) - $signed({20'd0, r_pdist});
    assign w_in_range = (r_root != '0) && (r_root <= {2'b00, r_lmax})
                        && (r_root >= {2'b00, r_lmin});

    assign w_fsum  = {{2{r_sf[49]}}, r_sf} + {{2{r_prod[65]}}, r_prod[65:16]};
    assign w_fclip = f_clip(w_fsum);

    assign w_f1x = {{19{r_fx[32]}}, r_fx} + {{2{r_dm1x[49]}}, r_dm1x};
    assign w_f1y = {{19{r_fy[32]}}, r_fy} + {{2{r_dm1y[49]}}, r_dm1y};
    assign w_f2x = {{2{r_dm2x[49]}}, r_dm2x} - {{19{r_fx[32]}}, r_fx};
    assign w_f2y = {{2{r_dm2y[49]}}, r_dm2y} - {{19{r_fy[32]}}, r_fy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiff  <= '0;
            r_ldamp  <= '0;
            r_rest   <= '0;
            r_mdamp  <= '0;
            r_lmin   <= '0;
            r_lmax   <= LEN_MAX_RST;
            r_muscle <= MUSCLE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_STIFFNESS: r_stiff  <= i_cfg_data;
                CFG_LINK_DAMP: r_ldamp  <= i_cfg_data;
                CFG_REST_LEN:  r_rest   <= i_cfg_data[30:0];
                CFG_MASS_DAMP: r_mdamp  <= i_cfg_data;
                CFG_LEN_MIN:   r_lmin   <= i_cfg_data[30:0];
                CFG_LEN_MAX:   r_lmax   <= i_cfg_data[30:0];
                CFG_MUSCLE:    r_muscle <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pm1x  <= '0;
            r_pm1y  <= '0;
            r_pm2x  <= '0;
            r_pm2y  <= '0;
            r_pdist <= '0;
        end else if (i_cmd.hist_clear) begin
            r_pm1x  <= '0;
            r_pm1y  <= '0;
            r_pm2x  <= '0;
            r_pm2y  <= '0;
            r_pdist <= {1'b0, r_rest};
        end else if (i_cmd.hist_load) begin
            r_pm1x  <= r_x1;
            r_pm1y  <= r_y1;
            r_pm2x  <= r_x2;
            r_pm2y  <= r_y2;
            r_pdist <= {1'b0, r_rest};
        end else if (i_cmd.fin) begin
            r_pm1x  <= r_x1;
            r_pm1y  <= r_y1;
            r_pm2x  <= r_x2;
            r_pm2y  <= r_y2;
            r_pdist <= r_root[32] ? 32'hffff_ffff : r_root[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (i_cmd.load) begin
            r_req <= t_req'(i_req_type);
            r_x1  <= i_mass1_x;
            r_y1  <= i_mass1_y;
            r_x2  <= i_mass2_x;
            r_y2  <= i_mass2_y;
        end
        if (i_cmd.diff) begin
            r_dx <= {r_x2[31], r_x2} - {r_x1[31], r_x1};
            r_dy <= {r_y2[31], r_y2} - {r_y1[31], r_y1};
        end
        unique case (i_cmd.cap)
            CAP_SQX:  r_sqx  <= r_prod[64:0];
            CAP_RAD:  r_rad  <= {1'b0, r_sqx} + {1'b0, r_prod[64:0]};
            CAP_TGT:  r_tgt  <= r_prod[65:16];
            CAP_DM1X: r_dm1x <= r_prod[65:16];
            CAP_DM1Y: r_dm1y <= r_prod[65:16];
            CAP_DM2X: r_dm2x <= r_prod[65:16];
            CAP_DM2Y: r_dm2y <= r_prod[65:16];
            CAP_SF:   r_sf   <= r_prod[65:16];
            CAP_F: begin
                r_af   <= w_fclip[31] ? 32'(-w_fclip) : w_fclip;
                r_fneg <= w_fclip[31];
            end
            CAP_NUMX: begin
                r_numx <= w_pmag;
                r_negx <= r_prod[65] ^ r_fneg;
            end
            CAP_NUMY: begin
                r_numy <= w_pmag;
                r_negy <= r_prod[65] ^ r_fneg;
            end
            default: ;
        endcase
        if (i_cmd.sqrt_init) begin
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_rad <= {r_rad[63:0], 2'b00};
            if (w_rsh >= w_trial) begin
                r_rem  <= w_rdiff[34:0];
                r_root <= {r_root[31:0], 1'b1};
            end else begin
                r_rem  <= w_rsh[34:0];
                r_root <= {r_root[31:0], 1'b0};
            end
        end
        if (i_cmd.div_init_x) begin
            r_drem <= r_numx[64:32];
            r_dq   <= r_numx[31:0];
        end else if (i_cmd.div_init_y) begin
            r_drem <= r_numy[64:32];
            r_dq   <= r_numy[31:0];
        end else if (i_cmd.div_step) begin
            if (!w_ddiff[33]) begin
                r_drem <= w_ddiff[32:0];
                r_dq   <= {r_dq[30:0], 1'b1};
            end else begin
                r_drem <= w_dsh[32:0];
                r_dq   <= {r_dq[30:0], 1'b0};
            end
        end
        if (i_cmd.chk && !w_in_range) begin
            r_fx <= '0;
            r_fy <= '0;
        end
        if (i_cmd.chk) begin
            r_err <= f_clip(w_err);
            r_chg <= f_clip(w_chg);
        end
        if (i_cmd.div_cap_x) begin
            r_fx <= r_negx ? -$signed({1'b0, r_dq}) : $signed({1'b0, r_dq});
        end
        if (i_cmd.div_cap_y) begin
            r_fy <= r_negy ? -$signed({1'b0, r_dq}) : $signed({1'b0, r_dq});
        end
        if (i_cmd.fin) begin
            r_f1x     <= f_clip(w_f1x);
            r_f1y     <= f_clip(w_f1y);
            r_f2x     <= f_clip(w_f2x);
            r_f2y     <= f_clip(w_f2y);
            r_out_sat <= r_sat | f_ovf(w_f1x) | f_ovf(w_f1y)
                         | f_ovf(w_f2x) | f_ovf(w_f2y);
        end
    end

    // saturation seen so far on this beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load) begin
            r_sat <= 1'b0;
        end else if (i_cmd.chk && w_in_range) begin
            r_sat <= r_sat | f_ovf(w_err) | f_ovf(w_chg);
        end else if (i_cmd.cap == CAP_F) begin
            r_sat <= r_sat | f_ovf(w_fsum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.req      = r_req;
    assign o_stat.in_range = w_in_range;
    assign o_stat.out_full = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_force1_x  = r_f1x;
    assign o_force1_y  = r_f1y;
    assign o_force2_x  = r_f2x;
    assign o_force2_y  = r_f2y;
    assign o_saturated = r_out_sat;

endmodule

### verif/spring_damper_link_2d_top_tb.sv
// self-checking testbench for spring_damper_link_2d_top: random and directed beats,
// forces predicted in-bench and compared against every output beat
// depends on sdl_pkg and the rtl of spring_damper_link_2d_top
module spring_damper_link_2d_top_tb;
    import sdl_pkg::*;

    typedef struct {
        t_req        req;
        logic [31:0] m1x, m1y, m2x, m2y;
    } t_item;

    typedef struct {
        logic [31:0] f1x, f1y, f2x, f2y;
        logic        sat;
    } t_force;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [1:0]  i_req_type = '0;
    logic [31:0] i_mass1_x = '0, i_mass1_y = '0, i_mass2_x = '0, i_mass2_y = '0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [31:0] o_force1_x, o_force1_y, o_force2_x, o_force2_y;
    logic        o_saturated;

    spring_damper_link_2d_top DUT (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // predictor state
    logic signed [31:0] k_stiff, k_ldamp, k_mdamp, k_muscle;
    logic [30:0]        k_rest, k_lmin, k_lmax;
    logic signed [31:0] h_m1x, h_m1y, h_m2x, h_m2y;
    logic [31:0]        h_dist;

    t_item  pending_items[$];
    t_force expected_forces[$];
    int     n_fail = 0;
    bit     calm = 0;
    bit     hold_long = 0;
    int     feed_gap = 0, drain_gap = 0;

    function automatic logic signed [63:0] fshr16(input logic signed [127:0] v);
        return 64'(v >>> 16);
    endfunction

    function automatic logic signed [63:0] clip_s32(input logic signed [63:0] v,
                                                    inout logic sat);
        if (v > 64'sd2147483647) begin sat = 1; return 64'sd2147483647; end
        if (v < -64'sd2147483648) begin sat = 1; return -64'sd2147483648; end
        return v;
    endfunction

    function automatic logic [63:0] isqrt66(input logic [66:0] v);
        logic [63:0] r;
        logic [63:0] c;
        r = 0;
        for (int b = 32; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (128'(c) * 128'(c) <= 128'(v)) r = c;
        end
        return r;
    endfunction

    function automatic t_force link_forces(input t_item it);
        t_force o;
        logic signed [63:0] dx, dy, fx, fy, tgt, err, chg, f, d2;
        logic signed [63:0] f1x, f1y, f2x, f2y;
        logic [63:0]        adx, ady, d, af, q;
        logic               sat;
        sat = 0; fx = 0; fy = 0;
        dx = 64'($signed(it.m2x)) - 64'($signed(it.m1x));
        dy = 64'($signed(it.m2y)) - 64'($signed(it.m1y));
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        d = isqrt66(67'(adx) * 67'(adx) + 67'(ady) * 67'(ady));
        if (d != 0 && d <= 64'(k_lmax) && d >= 64'(k_lmin)) begin
            tgt = fshr16(128'($signed({1'b0, k_rest})) * 128'(k_muscle));
            err = clip_s32($signed(d) - tgt, sat);
            chg = clip_s32($signed(d) - $signed(64'(h_dist)), sat);
            f = fshr16(128'(k_stiff) * 128'(err)) + fshr16(128'(k_ldamp) * 128'(chg));
            f = clip_s32(f, sat);
            af = f < 0 ? -f : f;
            q = (af * adx) / d;
            fx = ((f < 0) != (dx < 0)) ? -$signed(q) : $signed(q);
            q = (af * ady) / d;
            fy = ((f < 0) != (dy < 0)) ? -$signed(q) : $signed(q);
        end
        d2 = 64'(k_mdamp);
        f1x = fx + fshr16(128'(64'(h_m1x) - 64'($signed(it.m1x))) * 128'(d2));
        f1y = fy + fshr16(128'(64'(h_m1y) - 64'($signed(it.m1y))) * 128'(d2));
        f2x = -fx + fshr16(128'(64'(h_m2x) - 64'($signed(it.m2x))) * 128'(d2));
        f2y = -fy + fshr16(128'(64'(h_m2y) - 64'($signed(it.m2y))) * 128'(d2));
        o.f1x = 32'(clip_s32(f1x, sat));
        o.f1y = 32'(clip_s32(f1y, sat));
        o.f2x = 32'(clip_s32(f2x, sat));
        o.f2y = 32'(clip_s32(f2y, sat));
        o.sat = sat;
        h_dist = d > 64'hffff_ffff ? 32'hffff_ffff : 32'(d);
        return o;
    endfunction

    // updates history; returns 1 when a force beat is due
    function automatic bit track_beat(input t_item it, output t_force o);
        case (it.req)
            REQ_CLEAR: begin
                {h_m1x, h_m1y, h_m2x, h_m2y} = '0;
                h_dist = 32'(k_rest);
                return 0;
            end
            REQ_LOAD: begin
                {h_m1x, h_m1y, h_m2x, h_m2y} = {it.m1x, it.m1y, it.m2x, it.m2y};
                h_dist = 32'(k_rest);
                return 0;
            end
            REQ_COMPUTE: begin
                o = link_forces(it);
                {h_m1x, h_m1y, h_m2x, h_m2y} = {it.m1x, it.m1y, it.m2x, it.m2y};
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    function automatic void shadow_cfg(input t_cfg_idx idx, input logic [31:0] v);
        case (idx)
            CFG_STIFFNESS: k_stiff = v;
            CFG_LINK_DAMP: k_ldamp = v;
            CFG_REST_LEN:  k_rest = v[30:0];
            CFG_MASS_DAMP: k_mdamp = v;
            CFG_LEN_MIN:   k_lmin = v[30:0];
            CFG_LEN_MAX:   k_lmax = v[30:0];
            CFG_MUSCLE:    k_muscle = v;
            default: ;
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_force f;
        if (i_valid && o_ready) begin
            if (track_beat(pending_items[0], f)) expected_forces.push_back(f);
            void'(pending_items.pop_front());
        end
        if (feed_gap > 0) begin
            feed_gap <= feed_gap - 1;
            if (!(i_valid && !o_ready)) i_valid <= 0;
        end else if (i_valid && !o_ready) begin
        end else if (pending_items.size() > 0 && i_rst_n) begin
            t_item n;
            n = pending_items[0];
            if (!calm && $urandom_range(0, 9) == 0) begin
                feed_gap <= $urandom_range(1, 17);
                i_valid <= 0;
            end else begin
                i_valid <= 1;
                i_req_type <= n.req;
                {i_mass1_x, i_mass1_y, i_mass2_x, i_mass2_y} <= {n.m1x, n.m1y, n.m2x, n.m2y};
            end
        end else begin
            i_valid <= 0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_force e;
        if (o_valid && i_ready) begin
            if (expected_forces.size() == 0) begin
                $error("force beat with nothing expected");
                n_fail++;
            end else begin
                e = expected_forces.pop_front();
                if (o_force1_x !== e.f1x) begin
                    $error("force1_x exp %h got %h", e.f1x, o_force1_x); n_fail++;
                end
                if (o_force1_y !== e.f1y) begin
                    $error("force1_y exp %h got %h", e.f1y, o_force1_y); n_fail++;
                end
                if (o_force2_x !== e.f2x) begin
                    $error("force2_x exp %h got %h", e.f2x, o_force2_x); n_fail++;
                end
                if (o_force2_y !== e.f2y) begin
                    $error("force2_y exp %h got %h", e.f2y, o_force2_y); n_fail++;
                end
                if (o_saturated !== e.sat) begin
                    $error("saturated exp %b got %b", e.sat, o_saturated); n_fail++;
                end
            end
        end
        if (!i_rst_n || hold_long) begin
            i_ready <= 0;
        end else if (drain_gap > 0) begin
            drain_gap <= drain_gap - 1;
            i_ready <= 0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            drain_gap <= $urandom_range(1, 17);
            i_ready <= 0;
        end else begin
            i_ready <= 1;
        end
    end

    // long receiver hold-off
    initial begin
        wait (pending_items.size() > 200);
        @(posedge i_clk);
        hold_long <= 1;
        repeat (3000) @(posedge i_clk);
        hold_long <= 0;
    end

    function automatic logic [31:0] rand_pos(input int scale);
        case (scale)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 32'h3ff_ffff)) - 32'sh200_0000);
            default: return 32'($signed($urandom_range(0, 32'h1f_ffff)) - 32'sh10_0000);
        endcase
    endfunction

    function automatic t_item make_item(input t_req r, input int scale);
        t_item it;
        it.req = r;
        it.m1x = rand_pos(scale); it.m1y = rand_pos(scale);
        it.m2x = rand_pos(scale); it.m2y = rand_pos(scale);
        return it;
    endfunction

    task automatic push(input t_req r, input logic [31:0] a, b, c, d);
        t_item it;
        it.req = r; it.m1x = a; it.m1y = b; it.m2x = c; it.m2y = d;
        pending_items.push_back(it);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        shadow_cfg(idx, v);
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic drain_all();
        wait (pending_items.size() == 0 && !i_valid);
        wait (expected_forces.size() == 0);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic random_cfg(input int mode);
        write_reg(CFG_STIFFNESS, mode == 0 ? 32'h8000_0000 : mode == 1 ? 32'h7fff_ffff
                                           : $urandom_range(0, 32'h8_0000));
        write_reg(CFG_LINK_DAMP, mode == 0 ? 32'h7fff_ffff : mode == 1 ? 32'h8000_0000
                                           : $urandom_range(0, 32'h2_0000));
        write_reg(CFG_REST_LEN, mode == 0 ? 32'hffff_ffff : mode == 1 ? 32'h0
                                          : $urandom_range(0, 32'h80_0000));
        write_reg(CFG_MASS_DAMP, mode == 0 ? 32'h8000_0000 : mode == 1 ? 32'h7fff_ffff
                                           : $urandom_range(0, 32'h1_0000));
        write_reg(CFG_LEN_MIN, mode == 1 ? 32'h7fff_ffff : mode == 0 ? 32'h0
                                         : $urandom_range(0, 32'h4_0000));
        write_reg(CFG_LEN_MAX, mode == 0 ? 32'h7fff_ffff : mode == 1 ? 32'h0
                                         : $urandom_range(32'h100_0000, 32'h7fff_ffff));
        write_reg(CFG_MUSCLE, mode == 0 ? 32'h8000_0000 : mode == 1 ? 32'h7fff_ffff
                                        : $urandom_range(0, 32'h2_0000));
        write_reg(CFG_UNUSED, $urandom());
    endtask

    task automatic random_run(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 19);
            if (r == 0) pending_items.push_back(make_item(REQ_CLEAR, $urandom_range(0, 2)));
            else if (r == 1) pending_items.push_back(make_item(REQ_LOAD, $urandom_range(0, 2)));
            else if (r == 2) pending_items.push_back(make_item(REQ_NONE, 0));
            else pending_items.push_back(make_item(REQ_COMPUTE, $urandom_range(0, 2)));
        end
    endtask

    initial begin
        k_stiff = 0; k_ldamp = 0; k_rest = 0; k_mdamp = 0;
        k_lmin = 0; k_lmax = LEN_MAX_RST; k_muscle = MUSCLE_RST;
        {h_m1x, h_m1y, h_m2x, h_m2y, h_dist} = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;

        write_reg(CFG_STIFFNESS, 32'h0002_0000);
        write_reg(CFG_LINK_DAMP, 32'h0000_8000);
        write_reg(CFG_REST_LEN, 32'h0001_0000);
        write_reg(CFG_MASS_DAMP, 32'h0000_4000);
        // directed: zero length, extremes, limits, clear, load, unused type
        push(REQ_COMPUTE, 0, 0, 0, 0);
        push(REQ_COMPUTE, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        push(REQ_COMPUTE, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
        push(REQ_COMPUTE, 0, 0, 32'h0003_0000, 32'h0004_0000);
        push(REQ_COMPUTE, 32'h0001_0000, 0, 32'hffff_0000, 0);
        push(REQ_CLEAR, $urandom(), $urandom(), $urandom(), $urandom());
        push(REQ_COMPUTE, 32'h1000_0000, 0, 0, 32'h1000_0000);
        push(REQ_LOAD, 32'h0001_0000, 32'h0002_0000, 32'hfffe_0000, 32'h0005_0000);
        push(REQ_COMPUTE, 32'h0001_8000, 32'h0002_0000, 32'hfffe_0000, 32'h0004_0000);
        push(REQ_NONE, $urandom(), $urandom(), $urandom(), $urandom());
        push(REQ_COMPUTE, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        push(REQ_COMPUTE, 32'hffff_ffff, 32'hffff_ffff, 0, 0);
        push(REQ_COMPUTE, 0, 0, 32'h2000_0000, 32'h2000_0000);
        push(REQ_LOAD, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0);
        push(REQ_COMPUTE, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff);
        drain_all();

        for (int ph = 0; ph < 6; ph++) begin
            random_cfg(ph < 2 ? ph : 2);
            random_run(ph == 2 ? 300 : 200);
            drain_all();
        end
        calm = 1;
        random_cfg(2);
        random_run(150);
        drain_all();

        if (n_fail == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
